// File: rtl/core/workgroup_min_penalty_picker_assert.svh
// assertion macros for the work-group picker
// no dependencies
`ifndef WORKGROUP_MIN_PENALTY_PICKER_ASSERT_SVH
`define WORKGROUP_MIN_PENALTY_PICKER_ASSERT_SVH
// implication checked on every clock, off during reset
`define WMP_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication checked on every clock, off during reset
`define WMP_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// File: rtl/core/wmp_pkg.sv
// package for the work-group picker: constants, state type, base shape helper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wmp_pkg;
  localparam int THREAD_BUDGET_DEF = 512;
  localparam int GRID_BITS_DEF     = 16;
  localparam int BASE_THREADS      = 128;
  localparam int NUM_BASE          = 8;
  localparam int SMALL_X           = 16;
  localparam int SMALL_Y           = 8;
  localparam int GRID_W            = 16;
  localparam int OUT_XY_W          = 10;
  localparam int OUT_Z_W           = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD_X,
    ST_PAD_Y,
    ST_MUL_A,
    ST_MUL_B,
    ST_SCAN,
    ST_LIN,
    ST_DONE
  } state_t;

  // log2 of base x for shape b; base y is 7 - that
  function automatic logic [2:0] base_x_log(input logic [2:0] b);
    base_x_log = 3'(7 - int'(b));
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/wmp_if.sv
// valid/ready channel interface with a generic payload
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface wmp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/workgroup_min_penalty_picker.sv
// top level of the work-group size picker
// depends on wmp_pkg, wmp_if, wmp_divider and the assertion header
`timescale 1ns / 1ps
`default_nettype none
// Picks a work-group shape for a 3D grid. One request is taken at a time;
// the block is busy until the result is taken. In planar mode each candidate
// shape needs an x and a y remainder from one shared serial divider plus a
// multiply-accumulate in ST_MUL_A and ST_MUL_B; in linear mode each candidate
// needs only the x remainder. Small grids take the fixed shape without a
// search.
// linear_mode is written through cfg, which is ready only while the block is
// idle and no request is offered.
module workgroup_min_penalty_picker
  import wmp_pkg::*;
#(
  parameter int THREAD_BUDGET = THREAD_BUDGET_DEF,
  parameter int GRID_BITS     = GRID_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  wmp_if.sink       req,
  wmp_if.source     rsp,
  wmp_if.sink       cfg
);
  `include "workgroup_min_penalty_picker_assert.svh"

  localparam int SW  = $clog2(THREAD_BUDGET + 1) + 1;
  localparam int PW  = 2 * GRID_BITS + 2;
  localparam int GW  = GRID_BITS;

  // multiple of 3 test: 4 is 1 mod 3, so base-4 digit sums keep the residue
  function automatic logic mult_of_3(input logic [GW-1:0] v);
    logic [5:0] s;
    logic [3:0] t;
    s = 6'd0;
    for (int i = 0; i < GW; i++) begin
      if ((i % 2) == 0) s = s + {5'd0, v[i]};
      else s = s + {4'd0, v[i], 1'b0};
    end
    t = {2'd0, s[1:0]} + {2'd0, s[3:2]} + {2'd0, s[5:4]};
    mult_of_3 = (t == 4'd0) || (t == 4'd3) || (t == 4'd6) || (t == 4'd9);
  endfunction

  logic          linear_mode;
  state_t        state, state_next;
  logic [GW-1:0] gx, gy;
  logic [2:0]    oz;
  logic [SW-1:0] budget;
  logic          phase2;
  logic [2:0]    b;
  logic [SW-1:0] sx, sy;
  logic [SW-1:0] px, py;
  logic [PW-1:0] acc, target;
  logic [SW-1:0] ox, oy;
  logic          div_start, div_done;
  logic [GW-1:0] div_num;
  logic [SW-1:0] div_den;
  logic [SW-1:0] div_rem;
  logic [SW-1:0] pad_den;
  logic [SW-1:0] pad;
  logic [2*SW-1:0] thr;
  logic [GW-1:0] zm;
  logic          small_grid;
  logic [SW-1:0] step_x, step_y;
  logic          x_next, y_next;
  logic          scan_hit, scan_last, lin_last;

  // configuration register, written only between requests
  assign cfg.ready = (state == ST_IDLE) && !req.valid;
  always_ff @(posedge clk) begin
    if (rst) linear_mode <= 1'b0;
    else if (cfg.valid && cfg.ready) linear_mode <= cfg.data;
  end

  wmp_divider #(.NUM_W(GW), .DEN_W(SW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .rem(div_rem)
  );

  // padding from remainder against the divisor of the running division
  assign pad_den = (state == ST_PAD_Y) ? sx : sy;
  assign pad = (div_rem == '0) ? '0 : pad_den - div_rem;
  assign thr = sx * sy;
  assign zm  = req.data.grid_z[GW-1:0];

  // grids that take the fixed shape without a search
  assign small_grid = linear_mode ? (req.data.grid_x[GW-1:0] <= GW'(BASE_THREADS))
                                  : (req.data.grid_x[GW-1:0] <= GW'(SMALL_X) &&
                                     req.data.grid_y[GW-1:0] <= GW'(SMALL_Y));

  // search steps for the current base shape
  assign step_x    = SW'(1) << base_x_log(b);
  assign step_y    = SW'(1) << (3'd7 - base_x_log(b));
  assign x_next    = (2*SW)'(sx + step_x) * sy <= (2*SW)'(budget);
  assign y_next    = (2*SW)'(step_x) * (sy + step_y) <= (2*SW)'(budget);
  assign scan_hit  = phase2 && (acc == target) && (thr <= (2*SW)'(budget));
  assign scan_last = phase2 && !scan_hit && !x_next && !y_next && (b == 3'd7);
  assign lin_last  = (2*SW)'(sx) + (2*SW)'(BASE_THREADS) > (2*SW)'(budget);

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = (state == ST_DONE);
  assign rsp.data.group_x = OUT_XY_W'(ox);
  assign rsp.data.group_y = OUT_XY_W'(oy);
  assign rsp.data.group_z = oz;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = gx;
    div_den    = sx;
    case (state)
      ST_IDLE: if (req.valid) state_next = small_grid ? ST_DONE : ST_PAD_X;
      ST_PAD_X: begin
        div_start = 1'b1;
        state_next = ST_PAD_Y;
      end
      ST_PAD_Y: begin
        div_num = gy;
        div_den = sy;
        if (div_done) begin
          div_start = !linear_mode;
          state_next = linear_mode ? ST_LIN : ST_MUL_A;
        end
      end
      ST_MUL_A: if (div_done) state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_SCAN;
      ST_SCAN: state_next = (scan_hit || scan_last) ? ST_DONE : ST_PAD_X;
      ST_LIN: state_next = lin_last ? ST_DONE : ST_PAD_X;
      ST_DONE: if (rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (req.valid) begin
        gx <= req.data.grid_x[GW-1:0];
        gy <= req.data.grid_y[GW-1:0];
        if (zm[1:0] == 2'b00) begin
          oz <= 3'd4; budget <= SW'(THREAD_BUDGET / 4);
        end else if (zm[0] == 1'b0) begin
          oz <= 3'd2; budget <= SW'(THREAD_BUDGET / 2);
        end else if (mult_of_3(zm)) begin
          oz <= 3'd3; budget <= SW'(THREAD_BUDGET / 3);
        end else begin
          oz <= 3'd1; budget <= SW'(THREAD_BUDGET);
        end
        phase2 <= 1'b0;
        b  <= '0;
        target <= '1;
        if (linear_mode) begin
          ox <= SW'(BASE_THREADS); oy <= SW'(1);
          sx <= SW'(BASE_THREADS); sy <= SW'(BASE_THREADS);
        end else begin
          ox <= '0; oy <= '0;
          sx <= SW'(BASE_THREADS); sy <= SW'(1);
          if (small_grid) begin
            ox <= SW'(SMALL_X); oy <= SW'(SMALL_Y);
          end
        end
      end
      ST_PAD_Y: if (div_done) px <= pad;
      ST_MUL_A: if (div_done) begin
        py  <= pad;
        acc <= PW'(px * gy);
      end
      ST_MUL_B: acc <= acc + PW'(py * gx) + PW'(px * py);
      ST_SCAN: begin
        if (!phase2) begin
          if (acc < target) target <= acc;
          if (b == 3'd7) begin
            phase2 <= 1'b1; b <= '0;
            sx <= SW'(BASE_THREADS); sy <= SW'(1);
          end else begin
            b  <= b + 1'b1;
            sx <= SW'(1) << base_x_log(b + 1'b1);
            sy <= SW'(1) << (3'd7 - base_x_log(b + 1'b1));
          end
        end else if (scan_hit) begin
          ox <= sx; oy <= sy;
        end else if (x_next) begin
          // next x multiple, else next y multiple, else next base
          sx <= sx + step_x;
        end else if (y_next) begin
          sx <= step_x;
          sy <= sy + step_y;
        end else if (b != 3'd7) begin
          b  <= b + 1'b1;
          sx <= SW'(1) << base_x_log(b + 1'b1);
          sy <= SW'(1) << (3'd7 - base_x_log(b + 1'b1));
        end
      end
      ST_LIN: begin
        // first pass gives the target padding of 128
        if (!phase2) begin
          target <= PW'(px); phase2 <= 1'b1;
        end else if (PW'(px) == target) begin
          ox <= sx;
        end
        sx <= sx + SW'(BASE_THREADS);
      end
      default: ;
    endcase
  end

  // assertions
  `WMP_ASSERT_IMP(a_busy_no_req, clk, rst, state != ST_IDLE, !req.ready, "accepted while busy")
  `WMP_ASSERT_IMP(a_z_legal, clk, rst, rsp.valid, oz >= 3'd1 && oz <= 3'd4, "bad z size")
  `WMP_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid, "result dropped")
endmodule
`default_nettype wire

// File: rtl/core/wmp_divider.sv
// shared radix-2 remainder unit: one quotient bit per cycle
// depends on wmp_pkg
`timescale 1ns / 1ps
`default_nettype none
module wmp_divider
  import wmp_pkg::*;
#(
  parameter int NUM_W = 16,
  parameter int DEN_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [DEN_W-1:0]      rem
);
  localparam int CW = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] shreg;
  logic [DEN_W:0]   part;
  logic [DEN_W-1:0] dreg;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W+1:0] trial;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    trial = {part, shreg[NUM_W-1]} - {2'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      dreg  <= den;
      part  <= '0;
    end else if (busy) begin
      shreg <= {shreg[NUM_W-2:0], 1'b0};
      if (!trial[DEN_W+1]) part <= trial[DEN_W:0];
      else part <= {part[DEN_W-1:0], shreg[NUM_W-1]};
    end
  end

  assign rem = part[DEN_W-1:0];
endmodule
`default_nettype wire
